@@ rtl/core/bb3_pkg.sv @@
package bb3_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned ImgWidthW  = 11;
  localparam int unsigned ImgHeightW = 13;
  localparam logic [ImgWidthW-1:0]  ImgWidthRst  = 11'd640;
  localparam logic [ImgHeightW-1:0] ImgHeightRst = 13'd480;

  // apb register map
  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] AddrImgWidth  = 3'd0;
  localparam logic [AddrW-1:0] AddrImgHeight = 3'd4;

  // floor(s / 9) == (s * Recip9) >> Recip9Shift for every 3x3 sum of bytes
  localparam int unsigned SumW        = 12;
  localparam int unsigned Recip9W     = 14;
  localparam logic [Recip9W-1:0] Recip9 = 14'd7282;
  localparam int unsigned Recip9Shift = 16;
  localparam int unsigned ProdW       = SumW + Recip9W;

  // result queue
  localparam int unsigned OutDepth = 8;
  localparam int unsigned OutPtrW  = 3;
  localparam int unsigned OutCntW  = 4;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic   last;
    pixel_t pix;
  } result_t;

endpackage

@@ rtl/core/box_blur_3x3_rgb.sv @@
// pipeline: a result goes via the line read, window and sum registers into the output queue
//   after the beat that completes its window, one row plus one pixel after the pixel itself
// throughput: one beat in and one result out per cycle while credits last; the line memory takes
//   the read at the accepted column and the write back of the beat before it in the same cycle
// reset: counters and control registers clear at once; the line memory is then zeroed one entry
//   per cycle, MAX_WIDTH in all, with in_ready_o low; register writes are taken meanwhile
module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH  = bb3_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = bb3_pkg::MaxHeightDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bb3_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [7:0]                red_in_i,
  input  logic [7:0]                green_in_i,
  input  logic [7:0]                blue_in_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic                      frame_end_o
);
  import bb3_pkg::*;

  localparam int unsigned CLW = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned ORW = $clog2(MAX_HEIGHT);

  // ---------------- configuration ----------------
  logic [ImgWidthW-1:0]  img_width_q;
  logic [ImgHeightW-1:0] img_height_q;
  logic                  cfg_wr;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= ImgWidthRst;
      img_height_q <= ImgHeightRst;
    end else if (cfg_wr) begin
      if (paddr == AddrImgWidth) begin
        img_width_q <= pwdata[ImgWidthW-1:0];
      end else begin
        img_height_q <= pwdata[ImgHeightW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr == AddrImgWidth) begin
      prdata = 32'(img_width_q);
    end else begin
      prdata = 32'(img_height_q);
    end
  end

  always_comb begin
    if (img_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_width_q);
    end
    if (img_height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(img_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(img_height_q);
    end
  end

  // ---------------- memory clearing after reset ----------------
  logic           clr_q;
  logic [CLW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + CLW'(1);
      if (clr_addr_q == CLW'(MAX_WIDTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ---------------- input stage: position and credits ----------------
  logic [CLW-1:0]     in_col_q;
  logic [RW-1:0]      in_row_q;
  logic [OutCntW-1:0] cnt_q;
  logic               in_beat;
  logic               pixel_phase;
  logic               take;
  logic               produce0;
  logic               last0;
  logic               col_wrap;
  logic               out_beat;
  pixel_t             pix0;

  assign in_ready_o  = !clr_q && (cnt_q < OutCntW'(OutDepth));
  assign in_beat     = in_valid_i && in_ready_o;
  assign pixel_phase = in_row_q < RW'(h_eff);
  // a beat of the wrong kind is taken and dropped
  assign take        = in_beat && (req_type_i != pixel_phase);
  assign produce0    = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  // the beat one row plus one pixel past the frame delivers its last result
  assign last0       = (in_row_q == (RW'(h_eff) + RW'(1))) && (in_col_q == '0);
  assign col_wrap    = (WW'(in_col_q) + WW'(1)) >= w_eff;
  assign pix0        = req_type_i ? '0 : {red_in_i, green_in_i, blue_in_i};
  assign out_beat    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (cfg_wr) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (take) begin
      if (last0) begin
        in_col_q <= '0;
        in_row_q <= '0;
      end else if (col_wrap) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + RW'(1);
      end else begin
        in_col_q <= in_col_q + CLW'(1);
      end
    end
  end

  // results in flight plus queued, so the queue never overflows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + OutCntW'(take && produce0) - OutCntW'(out_beat);
    end
  end

  // ---------------- line memory: {newest row, older row} per column ----------------
  logic [47:0]    mem_q [MAX_WIDTH];
  logic [47:0]    rd_q;
  logic [47:0]    fwd_data_q;
  logic           fwd_q;
  logic           mem_we;
  logic [CLW-1:0] mem_wa;
  logic [47:0]    mem_wd;
  logic [47:0]    line;
  logic           p1_we;

  logic           p1_vld_q;
  logic           p1_prod_q;
  logic           p1_last_q;
  logic           p1_drain_q;
  logic [CLW-1:0] p1_col_q;
  pixel_t         p1_pix_q;

  // with a one-pixel row the next beat reads the entry being written
  assign line   = fwd_q ? fwd_data_q : rd_q;
  assign p1_we  = p1_vld_q && !p1_drain_q;
  assign mem_we = clr_q || p1_we;
  assign mem_wa = clr_q ? clr_addr_q : p1_col_q;
  assign mem_wd = clr_q ? '0 : {p1_pix_q, line[47:24]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (take) begin
      rd_q       <= mem_q[in_col_q];
      fwd_data_q <= mem_wd;
      p1_col_q   <= in_col_q;
      p1_pix_q   <= pix0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q   <= 1'b0;
      p1_prod_q  <= 1'b0;
      p1_last_q  <= 1'b0;
      p1_drain_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      p1_vld_q <= take;
      if (take) begin
        p1_prod_q  <= produce0;
        p1_last_q  <= last0;
        p1_drain_q <= req_type_i;
        fwd_q      <= p1_we && (p1_col_q == in_col_q);
      end
    end
  end

  // ---------------- window: columns oldest..newest, rows older/newer/incoming ----------------
  pixel_t win_q [9];
  logic   p2_vld_q;
  logic   p2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
      p2_vld_q  <= 1'b0;
      p2_last_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q && p1_prod_q;
      if (p1_vld_q) begin
        for (int k = 0; k < 6; k++) begin
          win_q[k] <= win_q[k+3];
        end
        win_q[6]  <= line[23:0];
        win_q[7]  <= line[47:24];
        win_q[8]  <= p1_pix_q;
        p2_last_q <= p1_last_q;
      end
    end
  end

  // ---------------- neighborhood sum with edge masking ----------------
  logic [CLW-1:0]  out_col_q;
  logic [ORW-1:0]  out_row_q;
  logic [2:0]      col_ok;
  logic [2:0]      row_ok;
  logic [SumW-1:0] col_sum [3][3];
  logic [SumW-1:0] sum    [3];
  logic [SumW-1:0] sum_q  [3];
  logic            p3_vld_q;
  logic            p3_last_q;

  assign col_ok[0] = out_col_q != '0;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = (WW'(out_col_q) + WW'(1)) < w_eff;
  assign row_ok[0] = out_row_q != '0;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = (HW'(out_row_q) + HW'(1)) < h_eff;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 3; j++) begin
        col_sum[ch][j] = '0;
        for (int r = 0; r < 3; r++) begin
          if (col_ok[j] && row_ok[r]) begin
            col_sum[ch][j] = col_sum[ch][j] + SumW'(win_q[3*j+r][16-8*ch +: 8]);
          end
        end
      end
      sum[ch] = col_sum[ch][0] + col_sum[ch][1] + col_sum[ch][2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q <= '0;
      out_row_q <= '0;
      p3_vld_q  <= 1'b0;
      p3_last_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
      if (cfg_wr) begin
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (p2_vld_q) begin
        p3_last_q <= p2_last_q;
        if (p2_last_q) begin
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (!col_ok[2]) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ORW'(1);
        end else begin
          out_col_q <= out_col_q + CLW'(1);
        end
      end
    end
  end

  // ---------------- divide by nine ----------------
  logic [ProdW-1:0] prod [3];
  result_t          res;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = ProdW'(sum_q[ch]) * ProdW'(Recip9);
    end
    res.last = p3_last_q;
    res.pix  = {prod[0][Recip9Shift +: 8], prod[1][Recip9Shift +: 8],
                prod[2][Recip9Shift +: 8]};
  end

  // ---------------- result queue ----------------
  result_t            fifo_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q;
  logic [OutPtrW-1:0] rd_ptr_q;
  logic [OutCntW-1:0] fifo_cnt_q;
  logic               fifo_push;
  result_t            head;

  assign fifo_push = p3_vld_q;

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + OutPtrW'(1);
      end
      if (out_beat) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + OutCntW'(fifo_push) - OutCntW'(out_beat);
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = fifo_cnt_q != '0;
  assign red_out_o   = head.pix[23:16];
  assign green_out_o = head.pix[15:8];
  assign blue_out_o  = head.pix[7:0];
  assign frame_end_o = head.last;

  // ---------------- assertions ----------------
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OutCntW'(OutDepth))
    else $error("result credit count exceeds queue depth");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_cnt_q != OutCntW'(OutDepth)) || out_beat)
    else $error("result pushed into a full queue");

  a_no_beat_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_ready_o)
    else $error("input beat offered while line memory is clearing");

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q && p1_vld_q |-> $past(p1_we))
    else $error("forwarded line data without a preceding write");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q && p2_last_q |=> (out_col_q == '0) && (out_row_q == '0))
    else $error("output position not restarted after last result of frame");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MaxW        = bb3_pkg::MaxWidthDef;
  localparam int unsigned MaxH        = bb3_pkg::MaxHeightDef;
  localparam int unsigned BoxArea     = 9;
  localparam int unsigned IdleSettle  = 16;
  localparam int unsigned StallLen    = 300;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned WideItems   = 1030;

  typedef struct packed {
    logic       drain;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } px_beat_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [bb3_pkg::AddrW-1:0] paddr       = '0;
  logic [31:0]               pwdata      = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic                      req_type_i  = 1'b0;
  logic [7:0]                red_in_i    = '0;
  logic [7:0]                green_in_i  = '0;
  logic [7:0]                blue_in_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [7:0]                red_out_o;
  logic [7:0]                green_out_o;
  logic [7:0]                blue_out_o;
  logic                      frame_end_o;

  box_blur_3x3_rgb DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .frame_end_o(frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0]                   line_a [MaxW];
  logic [23:0]                   line_b [MaxW];
  logic [23:0]                   win [9];
  int unsigned                   in_col  = 0;
  int unsigned                   in_row  = 0;
  int unsigned                   out_col = 0;
  int unsigned                   out_row = 0;
  logic [bb3_pkg::ImgWidthW-1:0]  cfg_width  = bb3_pkg::ImgWidthRst;
  logic [bb3_pkg::ImgHeightW-1:0] cfg_height = bb3_pkg::ImgHeightRst;

  px_beat_t          pixel_beats [$];
  px_beat_t          drive_beat;
  bb3_pkg::result_t  blur_expected [$];
  bb3_pkg::result_t  blur_want;

  bit          in_taken        = 1'b0;
  bit          hold_req        = 1'b0;
  int unsigned hold_cnt        = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned mismatches      = 0;
  int unsigned beats_accepted  = 0;
  int unsigned stim_items      = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done     = 0;
  int unsigned reg_writes      = 0;
  int unsigned cycle_count     = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void blur_predict(input logic drain, input logic [7:0] r, g, b);
    int unsigned      w;
    int unsigned      h;
    int unsigned      col;
    bit               produce;
    bit               col_ok [3];
    bit               row_ok [3];
    int unsigned      sum [3];
    bb3_pkg::result_t res;
    w = clamp_dim(cfg_width, MaxW);
    h = clamp_dim(cfg_height, MaxH);
    // wrong kind of beat for the current phase: no effect at all
    if (drain == (in_row < h)) return;
    col = (in_col >= MaxW) ? MaxW - 1 : in_col;
    for (int k = 0; k < 6; k++) win[k] = win[k + 3];
    win[6] = line_b[col];
    win[7] = line_a[col];
    win[8] = drain ? 24'h0 : {r, g, b};
    if (!drain) begin
      line_b[col] = line_a[col];
      line_a[col] = {r, g, b};
    end
    produce = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!produce) return;
    col_ok[0] = out_col > 0;
    col_ok[1] = 1'b1;
    col_ok[2] = out_col + 1 < w;
    row_ok[0] = out_row > 0;
    row_ok[1] = 1'b1;
    row_ok[2] = out_row + 1 < h;
    for (int ch = 0; ch < 3; ch++) sum[ch] = 0;
    // window index: column-major, k / 3 is the column, k % 3 the row
    for (int k = 0; k < 9; k++) begin
      if (col_ok[k / 3] && row_ok[k % 3]) begin
        for (int ch = 0; ch < 3; ch++) sum[ch] += win[k][16 - 8 * ch +: 8];
      end
    end
    for (int ch = 0; ch < 3; ch++) res.pix[16 - 8 * ch +: 8] = 8'(sum[ch] / BoxArea);
    res.last = (out_col + 1 >= w) && (out_row + 1 >= h);
    blur_expected.push_back(res);
    if (res.last) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_item(input logic drain, input logic [23:0] pix);
    pixel_beats.push_back({drain, pix});
  endfunction

  function automatic void push_beat(input logic drain);
    push_item(drain, {rand_chan(), rand_chan(), rand_chan()});
  endfunction

  task automatic write_reg(input logic [bb3_pkg::AddrW-1:0] addr, input logic [31:0] data);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == bb3_pkg::AddrImgWidth) begin
      cfg_width = data[bb3_pkg::ImgWidthW-1:0];
      want = 32'(cfg_width);
    end else begin
      cfg_height = data[bb3_pkg::ImgHeightW-1:0];
      want = 32'(cfg_height);
    end
    restart_positions();
    reg_writes++;
    // read back in the following transfer
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("readback at %0h: got %0h, expected %0h", addr, prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pixel_beats.size() != 0 || in_valid_i || blur_expected.size() != 0)
      @(posedge clk_i);
    // ignored beats leave nothing to wait for, give the pipeline time to settle
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  // one frame of pixels plus its drain beats, with stray beats of the wrong kind mixed in
  task automatic queue_frame(input bit cut);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned stop;
    w = clamp_dim(cfg_width, MaxW);
    h = clamp_dim(cfg_height, MaxH);
    total = w * h + w + 1;
    stop = cut ? $urandom_range(total - 1) : total;
    for (int unsigned n = 0; n < stop; n++) begin
      if ($urandom_range(24) == 0) push_beat(n < w * h);
      push_beat(n >= w * h);
      stim_items++;
    end
    if (!cut && $urandom_range(7) == 0) push_beat(1'b1);
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned start;
    int unsigned nfr;
    int unsigned w;
    int unsigned h;
    start = stim_items;
    while (stim_items - start < quota) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      write_reg(bb3_pkg::AddrImgWidth, ($urandom & ~32'h7FF) | w);
      if ($urandom_range(9) < 7) begin
        h = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
        write_reg(bb3_pkg::AddrImgHeight, ($urandom & ~32'h1FFF) | h);
      end
      nfr = $urandom_range(1, 3);
      for (int unsigned f = 1; f <= nfr; f++) queue_frame(f == nfr && $urandom_range(6) == 0);
      wait_idle();
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pixel_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_beat = pixel_beats.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= drive_beat.drain;
        red_in_i   <= drive_beat.r;
        green_in_i <= drive_beat.g;
        blue_in_i  <= drive_beat.b;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < StallLen) begin
      out_ready_i <= 1'b0;
      hold_cnt++;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      beats_accepted++;
      blur_predict(req_type_i, red_in_i, green_in_i, blue_in_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blur_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result rgb %02h%02h%02h frame_end %0b",
                                  red_out_o, green_out_o, blue_out_o, frame_end_o));
      end else begin
        blur_want = blur_expected.pop_front();
        if (red_out_o !== blur_want.pix[23:16])
          report_mismatch($sformatf("red_out got %02h, expected %02h",
                                    red_out_o, blur_want.pix[23:16]));
        if (green_out_o !== blur_want.pix[15:8])
          report_mismatch($sformatf("green_out got %02h, expected %02h",
                                    green_out_o, blur_want.pix[15:8]));
        if (blue_out_o !== blur_want.pix[7:0])
          report_mismatch($sformatf("blue_out got %02h, expected %02h",
                                    blue_out_o, blur_want.pix[7:0]));
        if (frame_end_o !== blur_want.last)
          report_mismatch($sformatf("frame_end got %0b, expected %0b",
                                    frame_end_o, blur_want.last));
        results_checked++;
        if (blur_want.last) frames_done++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, blur_expected.size());
      $display("box_blur_3x3_rgb verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MaxW; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 76;

    // 3x3 saturated frame but for zero blue in one corner, with stray beats of both kinds
    write_reg(bb3_pkg::AddrImgWidth, 32'd3);
    write_reg(bb3_pkg::AddrImgHeight, 32'd3);
    push_item(1'b1, 24'h5A5A5A);
    for (int i = 0; i < 9; i++) push_item(1'b0, (i == 8) ? 24'hFFFF00 : 24'hFFFFFF);
    push_item(1'b0, 24'hA5A5A5);
    for (int i = 0; i < 4; i++) push_item(1'b1, 24'h000000);
    push_item(1'b1, 24'hFFFFFF);
    stim_items += 13;
    wait_idle();

    // zero-sized registers act as a single pixel frame
    write_reg(bb3_pkg::AddrImgWidth, 32'd0);
    write_reg(bb3_pkg::AddrImgHeight, 32'd0);
    push_item(1'b0, 24'h7F00FF);
    push_item(1'b1, 24'h000000);
    push_item(1'b1, 24'h000000);
    stim_items += 3;
    wait_idle();

    run_phase(30);

    send_idle_pct = 76;
    recv_idle_pct = 38;
    run_phase(30);

    // full-rate frame against a long receiver hold-off, so the result queue fills
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    write_reg(bb3_pkg::AddrImgWidth, 32'd6);
    write_reg(bb3_pkg::AddrImgHeight, 32'd4);
    queue_frame(1'b0);
    wait_idle();

    // oversized registers clamp to the maximum frame; run past one full row
    write_reg(bb3_pkg::AddrImgWidth, 32'h7FF);
    write_reg(bb3_pkg::AddrImgHeight, 32'h1FFF);
    for (int i = 0; i < WideItems; i++) push_beat(1'b0);
    stim_items += WideItems;
    wait_idle();
    write_reg(bb3_pkg::AddrImgWidth, MaxW);
    write_reg(bb3_pkg::AddrImgHeight, MaxH);
    wait_idle();

    if (blur_expected.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", blur_expected.size()));
    $display("covered %0d accepted beats (%0d frame items), %0d results over %0d frames",
             beats_accepted, stim_items, results_checked, frames_done);
    $display("%0d register writes from zero to oversized, idle mixes and a %0d-cycle hold",
             reg_writes, StallLen);
    if (mismatches == 0) begin
      $display("box_blur_3x3_rgb verification clean");
    end else begin
      $display("box_blur_3x3_rgb verification failed");
    end
    $finish;
  end

endmodule
